// ===== design/aptc_pkg.sv =====
// ----------------------------------------------------------------------------
// aptc_pkg: shared types and constants of the AABB pair contact tracker
// Field widths, stream packing offsets and the contact event codes.
// ----------------------------------------------------------------------------
package aptc_pkg;

  localparam int unsigned ID_BITS    = 5;
  localparam int unsigned PAIR_BITS  = 2 * ID_BITS;
  localparam int unsigned PAIR_COUNT = 1 << PAIR_BITS;
  localparam int unsigned COORD_BITS = 16;

  // Input stream packing, lowest bit first.
  localparam int unsigned FIRST_ID_LSB  = 0;
  localparam int unsigned SECOND_ID_LSB = FIRST_ID_LSB + ID_BITS;
  localparam int unsigned FIRST_X_LSB   = SECOND_ID_LSB + ID_BITS;
  localparam int unsigned FIRST_Y_LSB   = FIRST_X_LSB + COORD_BITS;
  localparam int unsigned SECOND_X_LSB  = FIRST_Y_LSB + COORD_BITS;
  localparam int unsigned SECOND_Y_LSB  = SECOND_X_LSB + COORD_BITS;
  localparam int unsigned FIRST_W_LSB   = SECOND_Y_LSB + COORD_BITS;
  localparam int unsigned FIRST_H_LSB   = FIRST_W_LSB + COORD_BITS;
  localparam int unsigned SECOND_W_LSB  = FIRST_H_LSB + COORD_BITS;
  localparam int unsigned SECOND_H_LSB  = SECOND_W_LSB + COORD_BITS;
  localparam int unsigned ENABLE_LSB    = SECOND_H_LSB + COORD_BITS;
  localparam int unsigned IN_BITS       = ENABLE_LSB + 1;
  localparam int unsigned S_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;

  localparam int unsigned EVENT_BITS    = 2;
  localparam int unsigned M_TDATA_BITS  = ((EVENT_BITS + 7) / 8) * 8;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE  = 2'd0,
    EV_BEGIN = 2'd1,
    EV_STAY  = 2'd2,
    EV_END   = 2'd3
  } contact_event_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] size_t;
  typedef logic        [PAIR_BITS-1:0]  pair_idx_t;

endpackage

// ===== design/aptc_box_test.sv =====
// ----------------------------------------------------------------------------
// aptc_box_test: one-axis overlap test
// Flags touch when 2*|pos_a - pos_b| <= size_a + size_b, equality included.
// ----------------------------------------------------------------------------
module aptc_box_test (
  input  aptc_pkg::coord_t pos_a_i,
  input  aptc_pkg::coord_t pos_b_i,
  input  aptc_pkg::size_t  size_a_i,
  input  aptc_pkg::size_t  size_b_i,
  output logic             touch_o
);
  import aptc_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic        [COORD_BITS:0] mag;
  logic        [COORD_BITS:0] twice_mag;
  logic        [COORD_BITS:0] span;

  always_comb begin
    diff      = {pos_a_i[COORD_BITS-1], pos_a_i} - {pos_b_i[COORD_BITS-1], pos_b_i};
    mag       = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    twice_mag = {mag[COORD_BITS-1:0], 1'b0};
    span      = {1'b0, size_a_i} + {1'b0, size_b_i};
    touch_o   = (twice_mag <= span);
  end

endmodule

// ===== design/aabb_pair_contact_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker_unit: AABB pair contact tracker
// Tests one ordered collider pair per transfer and reports begin, stay, end
// or no contact, keeping one touch bit per ordered pair.
// ----------------------------------------------------------------------------
// One pair is taken per clock cycle and held in a stage register; its event
// then goes to the output register. A result held by the sink holds the input
// as well. The touch-bit memory has one read and one write port: it is read
// when a pair enters and written when its event leaves, with a bypass for the
// same pair arriving right behind. After reset the block runs a clearing pass
// over all 2^(2*ID_BITS) (1024) entries of that memory and takes no input
// transfer until it ends.
module aabb_pair_contact_tracker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // first_id, second_id, first_x, first_y, second_x, second_y, first_width,
  // first_height, second_width, second_height, pair_enabled, zero pad
  input  logic [aptc_pkg::S_TDATA_BITS-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // contact_event, zero pad
  output logic [aptc_pkg::M_TDATA_BITS-1:0]   m_axis_tdata_o
);
  import aptc_pkg::*;

  logic                 touch_mem [PAIR_COUNT];
  logic [PAIR_BITS:0]   clr_cnt_q;
  logic                 clearing;

  logic                 accept;
  pair_idx_t            in_idx;
  logic                 s1_valid_q;
  logic [IN_BITS-1:0]   s1_data_q;
  pair_idx_t            s1_idx_q;
  logic                 rd_q;
  logic                 fwd_hit_q;
  logic                 fwd_val_q;
  logic                 s1_advance;
  logic                 out_free;
  logic                 touch_x;
  logic                 touch_y;
  logic                 touch;
  logic                 prev;
  contact_event_e       event_d;
  contact_event_e       event_q;
  logic                 out_valid_q;

  assign clearing        = !clr_cnt_q[PAIR_BITS];
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_advance      = s1_valid_q && out_free;
  assign s_axis_tready_o = !clearing && (!s1_valid_q || out_free);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx          = {s_axis_tdata_i[FIRST_ID_LSB +: ID_BITS],
                            s_axis_tdata_i[SECOND_ID_LSB +: ID_BITS]};

  aptc_box_test u_test_x (
    .pos_a_i  (coord_t'(s1_data_q[FIRST_X_LSB +: COORD_BITS])),
    .pos_b_i  (coord_t'(s1_data_q[SECOND_X_LSB +: COORD_BITS])),
    .size_a_i (s1_data_q[FIRST_W_LSB +: COORD_BITS]),
    .size_b_i (s1_data_q[SECOND_W_LSB +: COORD_BITS]),
    .touch_o  (touch_x)
  );

  aptc_box_test u_test_y (
    .pos_a_i  (coord_t'(s1_data_q[FIRST_Y_LSB +: COORD_BITS])),
    .pos_b_i  (coord_t'(s1_data_q[SECOND_Y_LSB +: COORD_BITS])),
    .size_a_i (s1_data_q[FIRST_H_LSB +: COORD_BITS]),
    .size_b_i (s1_data_q[SECOND_H_LSB +: COORD_BITS]),
    .touch_o  (touch_y)
  );

  always_comb begin
    touch = s1_data_q[ENABLE_LSB] && touch_x && touch_y;
    prev  = fwd_hit_q ? fwd_val_q : rd_q;
    case ({touch, prev})
      2'b10:   event_d = EV_BEGIN;
      2'b11:   event_d = EV_STAY;
      2'b01:   event_d = EV_END;
      default: event_d = EV_NONE;
    endcase
  end

  // touch-bit memory: clearing sweep, write-back of the leaving pair, read
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      touch_mem[clr_cnt_q[PAIR_BITS-1:0]] <= 1'b0;
    end else if (s1_advance) begin
      touch_mem[s1_idx_q] <= touch;
    end
    if (accept) begin
      rd_q <= touch_mem[in_idx];
    end
  end

  // stage payload and bypass of the bit written in the same cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= s_axis_tdata_i[IN_BITS-1:0];
      s1_idx_q  <= in_idx;
      fwd_hit_q <= s1_advance && (s1_idx_q == in_idx);
      fwd_val_q <= touch;
    end
    if (s1_advance) begin
      event_q <= event_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_BITS - EVENT_BITS){1'b0}}, event_q};

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !s_axis_tready_o
  ) else $error("input transfer offered while clearing the touch memory");

  a_stage_empty_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !s1_valid_q && !out_valid_q
  ) else $error("pair in flight during clearing pass");

  a_stage_holds_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_idx_q)
  ) else $error("stalled pair lost or changed");

  a_advance_fills_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_advance |=> m_axis_tvalid_o
  ) else $error("event of an advancing pair not registered");

endmodule

// ===== tb/aabb_pair_contact_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker_unit_tb: self-checking bench for the contact tracker
// Streams ordered collider pairs into the block under random stalls on both
// sides. A scoreboard keeps its own touch bit per ordered pair, predicts the
// begin, stay, end or none event of every accepted pair, and compares it with
// each result transfer in order.
// ----------------------------------------------------------------------------
module aabb_pair_contact_tracker_unit_tb;
  import aptc_pkg::*;

  localparam int unsigned RANDOM_PAIRS = 2000;
  localparam int unsigned CALM_FROM    = 600;
  localparam int unsigned CALM_TO      = 800;
  localparam int unsigned DRAIN_AT     = 1000;
  localparam int unsigned QUIET_TAIL   = 300;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [ID_BITS-1:0] first_id;
    logic [ID_BITS-1:0] second_id;
    coord_t             first_x;
    coord_t             first_y;
    coord_t             second_x;
    coord_t             second_y;
    size_t              first_width;
    size_t              first_height;
    size_t              second_width;
    size_t              second_height;
    logic               pair_enabled;
  } collider_pair_t;

  class contact_scoreboard;
    bit             touching [PAIR_COUNT];
    contact_event_e awaited_events [$];
    int unsigned    mismatches;
    int unsigned    pairs_noted;
    int unsigned    seen_count [4];

    function bit axis_overlaps(coord_t c1, coord_t c2, size_t s1, size_t s2);
      int gap;
      gap = int'(c1) - int'(c2);
      if (gap < 0) gap = -gap;
      return (2 * gap) <= (int'(s1) + int'(s2));
    endfunction

    function void note_pair(collider_pair_t p);
      pair_idx_t slot;
      bit        now_touching;
      slot = {p.first_id, p.second_id};
      now_touching = p.pair_enabled &&
                     axis_overlaps(p.first_x, p.second_x, p.first_width, p.second_width) &&
                     axis_overlaps(p.first_y, p.second_y, p.first_height, p.second_height);
      pairs_noted++;
      if (now_touching) begin
        awaited_events.push_back(touching[slot] ? EV_STAY : EV_BEGIN);
        touching[slot] = 1'b1;
      end else begin
        awaited_events.push_back(touching[slot] ? EV_END : EV_NONE);
        touching[slot] = 1'b0;
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] MISMATCH #%0d: %s", $time, mismatches, what);
    endtask

    task check_event(logic [EVENT_BITS-1:0] got);
      contact_event_e want;
      if (awaited_events.size() == 0) begin
        report($sformatf("contact event %0d with nothing awaited", got));
      end else begin
        want = awaited_events.pop_front();
        seen_count[want]++;
        if (got !== want)
          report($sformatf("contact_event got %0d, want %0d (%s)", got, want, want.name()));
      end
    endtask

    function int pending();
      return awaited_events.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready_o;
  logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata_o;

  contact_scoreboard sb = new();
  bit                rx_idle_on = 1'b1;
  int unsigned       rx_stall_left = 0;

  aabb_pair_contact_tracker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** aabb_pair_contact_tracker_unit: FAILED **");
    $finish;
  end

  function automatic logic [S_TDATA_BITS-1:0] pack_pair(collider_pair_t p);
    logic [S_TDATA_BITS-1:0] word;
    word = '0;
    word[FIRST_ID_LSB  +: ID_BITS]    = p.first_id;
    word[SECOND_ID_LSB +: ID_BITS]    = p.second_id;
    word[FIRST_X_LSB   +: COORD_BITS] = p.first_x;
    word[FIRST_Y_LSB   +: COORD_BITS] = p.first_y;
    word[SECOND_X_LSB  +: COORD_BITS] = p.second_x;
    word[SECOND_Y_LSB  +: COORD_BITS] = p.second_y;
    word[FIRST_W_LSB   +: COORD_BITS] = p.first_width;
    word[FIRST_H_LSB   +: COORD_BITS] = p.first_height;
    word[SECOND_W_LSB  +: COORD_BITS] = p.second_width;
    word[SECOND_H_LSB  +: COORD_BITS] = p.second_height;
    word[ENABLE_LSB]                  = p.pair_enabled;
    return word;
  endfunction

  function automatic collider_pair_t unpack_pair(logic [S_TDATA_BITS-1:0] word);
    collider_pair_t p;
    p.first_id      = word[FIRST_ID_LSB  +: ID_BITS];
    p.second_id     = word[SECOND_ID_LSB +: ID_BITS];
    p.first_x       = word[FIRST_X_LSB   +: COORD_BITS];
    p.first_y       = word[FIRST_Y_LSB   +: COORD_BITS];
    p.second_x      = word[SECOND_X_LSB  +: COORD_BITS];
    p.second_y      = word[SECOND_Y_LSB  +: COORD_BITS];
    p.first_width   = word[FIRST_W_LSB   +: COORD_BITS];
    p.first_height  = word[FIRST_H_LSB   +: COORD_BITS];
    p.second_width  = word[SECOND_W_LSB  +: COORD_BITS];
    p.second_height = word[SECOND_H_LSB  +: COORD_BITS];
    p.pair_enabled  = word[ENABLE_LSB];
    return p;
  endfunction

  function automatic collider_pair_t make_pair(int fid, int sid, int fx, int fy, int sx,
                                               int sy, int fw, int fh, int sw, int sh,
                                               bit en);
    collider_pair_t p;
    p.first_id      = fid[ID_BITS-1:0];
    p.second_id     = sid[ID_BITS-1:0];
    p.first_x       = fx[COORD_BITS-1:0];
    p.first_y       = fy[COORD_BITS-1:0];
    p.second_x      = sx[COORD_BITS-1:0];
    p.second_y      = sy[COORD_BITS-1:0];
    p.first_width   = fw[COORD_BITS-1:0];
    p.first_height  = fh[COORD_BITS-1:0];
    p.second_width  = sw[COORD_BITS-1:0];
    p.second_height = sh[COORD_BITS-1:0];
    p.pair_enabled  = en;
    return p;
  endfunction

  function automatic int pick_id();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, (1 << ID_BITS) - 1);
    return $urandom_range(0, 3);
  endfunction

  // Place the second center within or just beyond the touch boundary of the two sizes.
  task automatic random_axis(output coord_t c1, output coord_t c2,
                             output size_t s1, output size_t s2);
    int half;
    int offset;
    if ($urandom_range(0, 7) == 0) begin
      s1 = size_t'($urandom());
      s2 = size_t'($urandom());
    end else begin
      s1 = size_t'($urandom_range(0, 2000));
      s2 = size_t'($urandom_range(0, 2000));
    end
    half = (int'(s1) + int'(s2)) / 2;
    offset = $urandom_range(0, half + 4);
    if ($urandom_range(0, 1) == 1) offset = -offset;
    c1 = coord_t'($urandom());
    c2 = c1 - offset[COORD_BITS-1:0];
  endtask

  task automatic random_pair(output collider_pair_t p);
    if ($urandom_range(0, 4) == 0) begin
      p = unpack_pair(S_TDATA_BITS'({$urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom()}));
    end else begin
      p.first_id     = ID_BITS'(pick_id());
      p.second_id    = ID_BITS'(pick_id());
      p.pair_enabled = ($urandom_range(0, 9) != 0);
      random_axis(p.first_x, p.second_x, p.first_width, p.second_width);
      random_axis(p.first_y, p.second_y, p.first_height, p.second_height);
    end
  endtask

  task automatic send_pair(collider_pair_t p, int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_pair(p);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o) sb.note_pair(unpack_pair(s_axis_tdata));
      if (m_axis_tvalid_o && m_axis_tready) sb.check_event(m_axis_tdata_o[EVENT_BITS-1:0]);
    end
  end

  initial begin
    collider_pair_t pair;
    int unsigned    gap;
    bit             idle_on;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 0);
    send_pair(make_pair(0, 0, 100, -100, 100, -100, 0, 0, 0, 0, 1'b1), 0);
    send_pair(make_pair(0, 0, 100, -100, 100, -100, 0, 0, 0, 0, 1'b1), 0);
    send_pair(make_pair(0, 0, 100, -100, 100, -100, 0, 0, 0, 0, 1'b0), 0);
    send_pair(make_pair(31, 31, -32768, 5, 32767, 5, 65535, 0, 65535, 0, 1'b1), 0);
    send_pair(make_pair(31, 31, -32768, 5, 32767, 5, 65535, 0, 65534, 0, 1'b1), 0);
    send_pair(make_pair(1, 2, 0, 0, 0, 10, 4, 10, 4, 10, 1'b1), 0);
    send_pair(make_pair(2, 1, 0, 0, 0, 10, 4, 10, 4, 10, 1'b1), 0);
    send_pair(make_pair(1, 2, 0, 0, 0, 10, 4, 10, 4, 10, 1'b1), 0);
    send_pair(make_pair(1, 2, 0, 0, 0, 11, 4, 10, 4, 10, 1'b1), 0);
    send_pair(make_pair(2, 1, 0, 0, 0, 11, 4, 10, 4, 10, 1'b1), 0);
    send_pair(make_pair(3, 4, 32767, 0, -32768, 0, 65535, 1, 65535, 1, 1'b1), 0);
    send_pair(make_pair(3, 4, 32767, 0, -32768, 0, 65535, 1, 65535, 1, 1'b1), 0);
    send_pair(make_pair(3, 4, 32767, 0, -32768, 0, 65534, 1, 65535, 1, 1'b1), 0);
    send_pair(make_pair(5, 6, 0, 0, 33, 0, 32, 8, 32, 8, 1'b1), 0);
    send_pair(make_pair(5, 6, 0, 0, 32, 0, 32, 8, 32, 8, 1'b1), 0);
    send_pair(make_pair(5, 6, 0, -32768, 32, 32767, 32, 65535, 32, 65535, 1'b1), 0);
    send_pair(make_pair(31, 31, -1, -1, -1, -1, 65535, 65535, 65535, 65535, 1'b1), 0);
    send_pair(make_pair(31, 31, -1, -1, -1, -1, 65535, 65535, 65535, 65535, 1'b1), 0);
    send_pair(make_pair(31, 31, -1, -1, -1, -1, 65535, 65535, 65535, 65535, 1'b0), 0);
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 0);
    send_pair(make_pair(7, 7, 0, 0, 1, 0, 0, 0, 0, 0, 1'b1), 0);

    for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
      idle_on = (n < CALM_FROM || n >= CALM_TO) && (n < RANDOM_PAIRS - QUIET_TAIL);
      rx_idle_on = idle_on;
      if (n == DRAIN_AT) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      random_pair(pair);
      send_pair(pair, gap);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d pair transfers under random stalls, with drained and calm stretches",
             sb.pairs_noted);
    $display("Events seen: none %0d, begin %0d, stay %0d, end %0d",
             sb.seen_count[EV_NONE], sb.seen_count[EV_BEGIN], sb.seen_count[EV_STAY],
             sb.seen_count[EV_END]);
    if (sb.mismatches == 0) begin
      $display("** aabb_pair_contact_tracker_unit: PASSED **");
    end else begin
      $display("** aabb_pair_contact_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule
